[src/swmf_pkg.sv]
// ============================================================================
// swmf_pkg: shared types and constants for the running median filter
// Sample width, default window size and the link word passed between the
// neighboring cells of the sorted chain.
// ============================================================================
package swmf_pkg;

    // Width of one light sample and of one result word.
    localparam int SAMPLE_W = 8;

    // Default number of samples held in the window.
    localparam int WINDOW_DEFAULT = 8;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // What one cell shows its neighbors: its stored value and whether that
    // value is greater than the incoming sample.
    typedef struct packed {
        sample_t value;
        logic    gt;
    } cell_link_t;

    // Links presented at the two ends of the chain. The low end acts as a
    // value below every sample, the high end as a value above every sample.
    localparam cell_link_t LINK_LOW_END  = '{value: '0, gt: 1'b0};
    localparam cell_link_t LINK_HIGH_END = '{value: '0, gt: 1'b1};

endpackage : swmf_pkg

[src/swmf_cell.sv]
// ============================================================================
// swmf_cell: one cell of the sorted insertion chain
// Holds one window sample with its age. On each accepted word the cell takes
// its own value, its neighbor's value or the new sample, so that the chain
// drops the oldest sample, inserts the new one and stays sorted.
// ============================================================================
module swmf_cell
    import swmf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT,
    parameter int AGE_W  = 3,
    parameter int INDEX  = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  sample_t          sample,
    input  cell_link_t       left_link,
    input  logic [AGE_W-1:0] left_age,
    input  logic             left_evict_le,
    input  cell_link_t       right_link,
    input  logic [AGE_W-1:0] right_age,
    input  logic             self_evict_le,
    output cell_link_t       self_link,
    output logic [AGE_W-1:0] self_age,
    output logic             evict,
    output sample_t          value_next
);

    sample_t          value_reg;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;

    logic             gr_self;
    logic             gr_left;
    sample_t          r_self_value;
    sample_t          r_left_value;
    logic [AGE_W-1:0] r_self_age;
    logic [AGE_W-1:0] r_left_age;

    // Local view shown to the neighbors.
    assign self_link.value = value_reg;
    assign self_link.gt    = (value_reg > sample);
    assign self_age        = age_reg;
    assign evict           = (age_reg == AGE_W'(WINDOW - 1));

    // Entries of the list once the oldest sample is taken out: at or above
    // the evicted place every entry moves down by one.
    always_comb begin
        r_self_value = self_evict_le ? right_link.value : value_reg;
        r_self_age   = self_evict_le ? right_age        : age_reg;
        gr_self      = self_evict_le ? right_link.gt    : self_link.gt;
        r_left_value = left_evict_le ? value_reg        : left_link.value;
        r_left_age   = left_evict_le ? age_reg          : left_age;
        gr_left      = left_evict_le ? self_link.gt     : left_link.gt;
    end

    // Insert the new sample where the remaining list first exceeds it.
    always_comb begin
        if (!gr_self) begin
            value_next = r_self_value;
            age_next   = r_self_age + AGE_W'(1);
        end else if (!gr_left) begin
            value_next = sample;
            age_next   = '0;
        end else begin
            value_next = r_left_value;
            age_next   = r_left_age + AGE_W'(1);
        end
    end

    // Reset gives a window of zeros with distinct ages in cell order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            age_reg   <= AGE_W'(INDEX);
        end else if (load) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule : swmf_cell

[src/sliding_window_median_filter.sv]
// ============================================================================
// sliding_window_median_filter: running median over the last WINDOW samples
// A sorted chain of cells drops the oldest sample and inserts the new one on
// every accepted word; the median is read from the middle cells.
// ============================================================================
//
//  Channel  Ports                        Direction  Word
//  -------  ---------------------------  ---------  --------------------------
//  input    s_valid s_ready s_sample     in         one 8-bit light sample
//  result   m_valid m_ready              out        one 8-bit median value
//           m_median_value
//
// One word is accepted per cycle while s_ready is high; its median appears
// in the output register on the next cycle.
// The cell chain update and the middle-pair add are combinational logic in
// front of the output register.
// After reset the window holds WINDOW zeros and no result is pending.
// A stalled result holds the input side only while the output register is
// full and m_ready is low.
//
module sliding_window_median_filter
    import swmf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_sample,
    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_median_value
);

    localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MID   = WINDOW / 2;

    logic             load;
    cell_link_t       link     [WINDOW];
    logic [AGE_W-1:0] age      [WINDOW];
    sample_t          val_next [WINDOW];
    logic [WINDOW-1:0] evict_vec;
    logic [WINDOW-1:0] evict_le;

    sample_t median_next;
    logic    m_valid_reg;
    logic    m_valid_next;
    sample_t m_median_value_reg;

    // Input is taken whenever the output register is free or being emptied.
    assign s_ready = !m_valid_reg || m_ready;
    assign load    = s_valid && s_ready;

    // Chain of cells, each linked to its two neighbors.
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        cell_link_t       left_link;
        logic [AGE_W-1:0] left_age;
        logic             left_evict_le;
        cell_link_t       right_link;
        logic [AGE_W-1:0] right_age;

        // Marks the cells at or above the one holding the oldest sample.
        assign evict_le[i] = |evict_vec[i:0];

        if (i == 0) begin : g_low
            assign left_link     = LINK_LOW_END;
            assign left_age      = '0;
            assign left_evict_le = 1'b0;
        end else begin : g_mid_low
            assign left_link     = link[i-1];
            assign left_age      = age[i-1];
            assign left_evict_le = evict_le[i-1];
        end

        if (i == WINDOW - 1) begin : g_high
            assign right_link = LINK_HIGH_END;
            assign right_age  = '0;
        end else begin : g_mid_high
            assign right_link = link[i+1];
            assign right_age  = age[i+1];
        end

        swmf_cell #(
            .WINDOW (WINDOW),
            .AGE_W  (AGE_W),
            .INDEX  (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .load          (load),
            .sample        (s_sample),
            .left_link     (left_link),
            .left_age      (left_age),
            .left_evict_le (left_evict_le),
            .right_link    (right_link),
            .right_age     (right_age),
            .self_evict_le (evict_le[i]),
            .self_link     (link[i]),
            .self_age      (age[i]),
            .evict         (evict_vec[i]),
            .value_next    (val_next[i])
        );
    end

    // Median of the updated window: the middle cell, or the floor mean of
    // the middle pair for an even window.
    if ((WINDOW % 2) == 0) begin : g_even
        logic [SAMPLE_W:0] pair_sum;
        assign pair_sum    = {1'b0, val_next[MID-1]} + {1'b0, val_next[MID]};
        assign median_next = pair_sum[SAMPLE_W:1];
    end else begin : g_odd
        assign median_next = val_next[MID];
    end

    // Output register valid control.
    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result word, loaded with each accepted sample.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_median_value_reg <= median_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_median_value = m_median_value_reg;

`ifndef ASSERT_OFF
    // Exactly one cell holds the oldest sample at all times.
    a_one_oldest: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(evict_vec))
        else $error("oldest-sample marker is not one-hot");

    // An accepted sample always leaves a result in the output register.
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("accepted sample produced no result");

    // The input side stalls only behind a held result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready))
        else $error("input stalled without a held result");
`endif

endmodule : sliding_window_median_filter
